// ===== rtl/core/vbs_pkg.sv =====
// Shared constants and types for the voxel block store.
package vbs_pkg;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned REQ_W   = 2;

  localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FILL  = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [VALUE_W-1:0]        value_t;

endpackage

// ===== rtl/core/vbs_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module vbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/vbs_index.sv =====
// Three-stage index unit: linear cell index, range check and fill box setup.
module vbs_index #(
  parameter int unsigned GRID_WIDTH  = 16,
  parameter int unsigned GRID_DEPTH  = 16,
  parameter int unsigned GRID_HEIGHT = 256,
  localparam int unsigned CELL_COUNT = GRID_WIDTH * GRID_DEPTH * GRID_HEIGHT,
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT),
  localparam int unsigned XW         = $clog2(GRID_WIDTH),
  localparam int unsigned YW         = $clog2(GRID_HEIGHT),
  localparam int unsigned ZW         = $clog2(GRID_DEPTH)
) (
  input  logic                clk_i,
  input  logic                load_i,
  input  vbs_pkg::coord_t     x_a_i,
  input  vbs_pkg::coord_t     y_a_i,
  input  vbs_pkg::coord_t     z_a_i,
  input  vbs_pkg::coord_t     x_b_i,
  input  vbs_pkg::coord_t     y_b_i,
  input  vbs_pkg::coord_t     z_b_i,
  output logic                idx_ok_o,
  output logic [ADDR_W-1:0]   idx_o,
  output logic                same_o,
  output logic [ADDR_W-1:0]   start_o,
  output logic [XW-1:0]       x0_o,
  output logic [XW-1:0]       x1_o,
  output logic [YW-1:0]       y0_o,
  output logic [YW-1:0]       y1_o,
  output logic [ZW-1:0]       z0_o,
  output logic [ZW-1:0]       z1_o
);

  localparam int unsigned COORD_W = vbs_pkg::COORD_W;
  // |x + W*z + W*D*y| stays below 2^(11+XW+ZW); one more bit for the sign
  localparam int unsigned LIN_W   = COORD_W + 1 + XW + ZW;

  localparam logic signed [LIN_W-1:0] WIDTH_S = LIN_W'(GRID_WIDTH);
  localparam logic signed [LIN_W-1:0] DEPTH_S = LIN_W'(GRID_DEPTH);
  localparam logic signed [LIN_W-1:0] CELL_S  = LIN_W'(CELL_COUNT);
  localparam vbs_pkg::coord_t X_HI = COORD_W'(GRID_WIDTH - 1);
  localparam vbs_pkg::coord_t Y_HI = COORD_W'(GRID_HEIGHT - 1);
  localparam vbs_pkg::coord_t Z_HI = COORD_W'(GRID_DEPTH - 1);

  function automatic logic [COORD_W-1:0] clamp_axis(vbs_pkg::coord_t v, vbs_pkg::coord_t hi);
    logic [COORD_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic vbs_pkg::coord_t min_c(vbs_pkg::coord_t a, vbs_pkg::coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic vbs_pkg::coord_t max_c(vbs_pkg::coord_t a, vbs_pkg::coord_t b);
    return (a < b) ? b : a;
  endfunction

  vbs_pkg::coord_t xa_q, ya_q, za_q, xb_q, yb_q, zb_q;

  logic signed [LIN_W-1:0] t1_q;
  logic                    same1_q;
  logic [XW-1:0]           x0_q, x1_q;
  logic [YW-1:0]           y0_q, y1_q;
  logic [ZW-1:0]           z0_q, z1_q;

  logic signed [LIN_W-1:0] idx2_q;
  logic [ADDR_W-1:0]       ft2_q;

  logic                    ok3_q;
  logic [ADDR_W-1:0]       idx3_q;
  logic [ADDR_W-1:0]       start3_q;

  // capture the request coordinates
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      xa_q <= x_a_i;
      ya_q <= y_a_i;
      za_q <= z_a_i;
      xb_q <= x_b_i;
      yb_q <= y_b_i;
      zb_q <= z_b_i;
    end
  end

  // stage 1: z + D*y, order and clamp the fill corners
  always_ff @(posedge clk_i) begin
    t1_q    <= LIN_W'(za_q) + LIN_W'(ya_q) * DEPTH_S;
    same1_q <= (xa_q == xb_q) && (ya_q == yb_q) && (za_q == zb_q);
    x0_q    <= XW'(clamp_axis(min_c(xa_q, xb_q), X_HI));
    x1_q    <= XW'(clamp_axis(max_c(xa_q, xb_q), X_HI));
    y0_q    <= YW'(clamp_axis(min_c(ya_q, yb_q), Y_HI));
    y1_q    <= YW'(clamp_axis(max_c(ya_q, yb_q), Y_HI));
    z0_q    <= ZW'(clamp_axis(min_c(za_q, zb_q), Z_HI));
    z1_q    <= ZW'(clamp_axis(max_c(za_q, zb_q), Z_HI));
  end

  // stage 2: full linear index, and z0 + D*y0 for the box origin
  always_ff @(posedge clk_i) begin
    idx2_q <= LIN_W'(xa_q) + t1_q * WIDTH_S;
    ft2_q  <= ADDR_W'(z0_q) + ADDR_W'(y0_q) * ADDR_W'(GRID_DEPTH);
  end

  // stage 3: range check on the index only, box origin address
  always_ff @(posedge clk_i) begin
    ok3_q    <= (idx2_q >= 0) && (idx2_q < CELL_S);
    idx3_q   <= idx2_q[ADDR_W-1:0];
    start3_q <= ADDR_W'(x0_q) + ADDR_W'(GRID_WIDTH) * ft2_q;
  end

  assign idx_ok_o = ok3_q;
  assign idx_o    = idx3_q;
  assign same_o   = same1_q;
  assign start_o  = start3_q;
  assign x0_o     = x0_q;
  assign x1_o     = x1_q;
  assign y0_o     = y0_q;
  assign y1_o     = y1_q;
  assign z0_o     = z0_q;
  assign z1_o     = z1_q;

endmodule

// ===== rtl/core/vbs_walker.sv =====
// Box fill walker: steps the cell address x innermost, then y, then z.
module vbs_walker #(
  parameter int unsigned GRID_WIDTH  = 16,
  parameter int unsigned GRID_DEPTH  = 16,
  parameter int unsigned GRID_HEIGHT = 256,
  localparam int unsigned CELL_COUNT = GRID_WIDTH * GRID_DEPTH * GRID_HEIGHT,
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT),
  localparam int unsigned XW         = $clog2(GRID_WIDTH),
  localparam int unsigned YW         = $clog2(GRID_HEIGHT),
  localparam int unsigned ZW         = $clog2(GRID_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              step_i,
  input  logic [ADDR_W-1:0] start_addr_i,
  input  logic [XW-1:0]     x0_i,
  input  logic [XW-1:0]     x1_i,
  input  logic [YW-1:0]     y0_i,
  input  logic [YW-1:0]     y1_i,
  input  logic [ZW-1:0]     z0_i,
  input  logic [ZW-1:0]     z1_i,
  output logic [ADDR_W-1:0] addr_o,
  output logic              last_o
);

  localparam logic [ADDR_W-1:0] Z_STEP = ADDR_W'(GRID_WIDTH);
  localparam logic [ADDR_W-1:0] Y_STEP = ADDR_W'(GRID_WIDTH * GRID_DEPTH);

  logic [XW-1:0]     x_q, x_d;
  logic [YW-1:0]     y_q, y_d;
  logic [ZW-1:0]     z_q, z_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] ystart_q, ystart_d;
  logic [ADDR_W-1:0] zstart_q, zstart_d;

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    addr_d   = addr_q;
    ystart_d = ystart_q;
    zstart_d = zstart_q;
    if (start_i) begin
      x_d      = x0_i;
      y_d      = y0_i;
      z_d      = z0_i;
      addr_d   = start_addr_i;
      ystart_d = start_addr_i;
      zstart_d = start_addr_i;
    end else if (step_i) begin
      if (x_q != x1_i) begin
        x_d    = x_q + 1'b1;
        addr_d = addr_q + 1'b1;
      end else if (y_q != y1_i) begin
        // next row along y: W*D cells further on
        x_d      = x0_i;
        y_d      = y_q + 1'b1;
        ystart_d = ystart_q + Y_STEP;
        addr_d   = ystart_q + Y_STEP;
      end else if (z_q != z1_i) begin
        x_d      = x0_i;
        y_d      = y0_i;
        z_d      = z_q + 1'b1;
        zstart_d = zstart_q + Z_STEP;
        ystart_d = zstart_q + Z_STEP;
        addr_d   = zstart_q + Z_STEP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      z_q      <= '0;
      addr_q   <= '0;
      ystart_q <= '0;
      zstart_q <= '0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
      addr_q   <= addr_d;
      ystart_q <= ystart_d;
      zstart_q <= zstart_d;
    end
  end

  assign addr_o = addr_q;
  assign last_o = (x_q == x1_i) && (y_q == y1_i) && (z_q == z1_i);

endmodule

// ===== rtl/core/voxel_block_store_box_fill_top.sv =====
// Voxel block store with box fill: top level, request sequencer and store.
//
// A request is taken when start is high and busy is low. It reads a cell,
// writes a cell, or fills the box spanned by two corners. Every request
// gives exactly one transaction on the result ports: done_o is high for one
// cycle with read_value_o and index_valid_o; the receiver cannot stall it.
// The cell index is x + W*(z + D*y), range-checked only as a whole.
// After the accepting edge a request passes IDX1, IDX2 and IDX3 to EXEC.
// A write, an unused request type or a fill with equal corners ends in
// EXEC; a read goes on through RDATA for the registered store read, and a
// box fill through FILL, which writes one cell per cycle through the single
// store port. busy stays high for the whole request, so one request is
// worked on at a time; the next may start in the cycle done_o is shown.
// The store is one single-port RAM of GRID_WIDTH*GRID_DEPTH*GRID_HEIGHT
// entries (65536 with the default grid). After reset it is cleared to air
// by a pass that writes one entry a cycle, during which busy is high.
module voxel_block_store_box_fill_top #(
  parameter int unsigned GRID_WIDTH  = 16,
  parameter int unsigned GRID_DEPTH  = 16,
  parameter int unsigned GRID_HEIGHT = 256,
  parameter int unsigned BLOCK_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [vbs_pkg::REQ_W-1:0]     req_type_i,
  input  vbs_pkg::coord_t               x_a_i,
  input  vbs_pkg::coord_t               y_a_i,
  input  vbs_pkg::coord_t               z_a_i,
  input  vbs_pkg::coord_t               x_b_i,
  input  vbs_pkg::coord_t               y_b_i,
  input  vbs_pkg::coord_t               z_b_i,
  input  vbs_pkg::value_t               block_value_i,
  output logic                          done_o,
  output vbs_pkg::value_t               read_value_o,
  output logic                          index_valid_o
);

  localparam int unsigned CELL_COUNT = GRID_WIDTH * GRID_DEPTH * GRID_HEIGHT;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned XW         = $clog2(GRID_WIDTH);
  localparam int unsigned YW         = $clog2(GRID_HEIGHT);
  localparam int unsigned ZW         = $clog2(GRID_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_IDX1  = 3'd2;
  localparam logic [2:0] S_IDX2  = 3'd3;
  localparam logic [2:0] S_IDX3  = 3'd4;
  localparam logic [2:0] S_EXEC  = 3'd5;
  localparam logic [2:0] S_RDATA = 3'd6;
  localparam logic [2:0] S_FILL  = 3'd7;

  logic [2:0]                state_q, state_d;
  logic [ADDR_W-1:0]         clr_q, clr_d;
  logic [vbs_pkg::REQ_W-1:0] req_q;
  logic [BLOCK_BITS-1:0]     val_q;
  logic                      done_q, done_d;
  vbs_pkg::value_t           rv_q, rv_d;
  logic                      iv_q, iv_d;

  logic                      accept;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [BLOCK_BITS-1:0]     ram_wdata;
  logic [BLOCK_BITS-1:0]     ram_rdata;

  logic                      idx_ok;
  logic [ADDR_W-1:0]         idx;
  logic                      same;
  logic [ADDR_W-1:0]         box_start;
  logic [XW-1:0]             x0, x1;
  logic [YW-1:0]             y0, y1;
  logic [ZW-1:0]             z0, z1;
  logic                      walk_start;
  logic                      walk_step;
  logic [ADDR_W-1:0]         walk_addr;
  logic                      walk_last;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      val_q <= BLOCK_BITS'(block_value_i);
    end
  end

  vbs_index #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_DEPTH (GRID_DEPTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_index (
    .clk_i   (clk_i),
    .load_i  (accept),
    .x_a_i   (x_a_i),
    .y_a_i   (y_a_i),
    .z_a_i   (z_a_i),
    .x_b_i   (x_b_i),
    .y_b_i   (y_b_i),
    .z_b_i   (z_b_i),
    .idx_ok_o(idx_ok),
    .idx_o   (idx),
    .same_o  (same),
    .start_o (box_start),
    .x0_o    (x0),
    .x1_o    (x1),
    .y0_o    (y0),
    .y1_o    (y1),
    .z0_o    (z0),
    .z1_o    (z1)
  );

  vbs_walker #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_DEPTH (GRID_DEPTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (walk_start),
    .step_i      (walk_step),
    .start_addr_i(box_start),
    .x0_i        (x0),
    .x1_i        (x1),
    .y0_i        (y0),
    .y1_i        (y1),
    .z0_i        (z0),
    .z1_i        (z1),
    .addr_o      (walk_addr),
    .last_o      (walk_last)
  );

  vbs_ram #(
    .WIDTH(BLOCK_BITS),
    .DEPTH(CELL_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    ram_we     = 1'b0;
    ram_addr   = idx;
    ram_wdata  = val_q;
    done_d     = 1'b0;
    rv_d       = '0;
    iv_d       = 1'b0;
    walk_start = 1'b0;
    walk_step  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_CELL) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_IDX1;
        end
      end
      S_IDX1: state_d = S_IDX2;
      S_IDX2: state_d = S_IDX3;
      S_IDX3: state_d = S_EXEC;
      S_EXEC: begin
        case (req_q)
          vbs_pkg::REQ_READ: begin
            if (idx_ok) begin
              state_d = S_RDATA;
            end else begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
          vbs_pkg::REQ_WRITE: begin
            ram_we  = idx_ok;
            iv_d    = idx_ok;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          vbs_pkg::REQ_FILL: begin
            if (same) begin
              // equal corners: plain single-cell write
              ram_we  = idx_ok;
              iv_d    = idx_ok;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              walk_start = 1'b1;
              state_d    = S_FILL;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_RDATA: begin
        rv_d    = vbs_pkg::VALUE_W'(ram_rdata);
        iv_d    = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_addr  = walk_addr;
        walk_step = 1'b1;
        if (walk_last) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rv_q <= rv_d;
    iv_q <= iv_d;
  end

  assign done_o        = done_q;
  assign read_value_o  = rv_q;
  assign index_valid_o = iv_q;

endmodule
